// ----- rtl/core/sclru_pkg.sv -----
// Shared constants for the set-associative LRU tag lookup.
package sclru_pkg;

  // Fixed field widths of the access and result words
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned CNT_W  = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Decoupling queue between the front and the back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Back-end sequencer states
  typedef enum logic [1:0] {
    S_READ = 2'b01,
    S_EVAL = 2'b10
  } back_state_e;

endpackage

// ----- rtl/core/sclru_front.sv -----
// Front end: accept access words and split each address into set index and tag.
module sclru_front #(
  parameter int unsigned SET_COUNT        = 64,
  parameter int unsigned LINE_OFFSET_BITS = 6,
  parameter int unsigned TAG_BITS         = 24,
  parameter int unsigned SET_IDX_W        = 6
) (
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [sclru_pkg::ADDR_W-1:0] address_i,
  output logic                         push_valid_o,
  input  logic                         push_ready_i,
  output logic [SET_IDX_W-1:0]         push_set_o,
  output logic [TAG_BITS-1:0]          push_tag_o
);
  import sclru_pkg::*;

  localparam int unsigned SET_SHIFT = $clog2(SET_COUNT);

  logic [ADDR_W-1:0] line;

  // Drop the byte offset, then take the set index from the low line bits
  always_comb begin
    line = address_i >> LINE_OFFSET_BITS;
    if (SET_COUNT == 1) begin
      push_set_o = '0;
    end else begin
      push_set_o = SET_IDX_W'(line);
    end
    push_tag_o = TAG_BITS'(line >> SET_SHIFT);
  end

  // Pass the handshake straight to the queue
  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule

// ----- rtl/core/sclru_queue.sv -----
// Short FIFO that decouples the decode front end from the lookup back end.
module sclru_queue #(
  parameter int unsigned DATA_W = 30
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] pop_data_o
);
  import sclru_pkg::*;

  logic [DATA_W-1:0] entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/core/sclru_back.sv -----
// Back end: read one set row, look up the tag, reorder the LRU list, write back, count.
module sclru_back #(
  parameter int unsigned SET_COUNT = 64,
  parameter int unsigned WAY_COUNT = 8,
  parameter int unsigned TAG_BITS  = 24,
  parameter int unsigned SET_IDX_W = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  output logic                        q_pop_o,
  input  logic [SET_IDX_W-1:0]        q_set_i,
  input  logic [TAG_BITS-1:0]         q_tag_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic [sclru_pkg::CNT_W-1:0] hit_total_o,
  output logic [sclru_pkg::CNT_W-1:0] miss_total_o
);
  import sclru_pkg::*;

  localparam int unsigned FILL_W = $clog2(WAY_COUNT + 1);
  localparam int unsigned ROW_W  = WAY_COUNT * TAG_BITS;

  back_state_e state_q, state_d;

  // Set rows: way 0 is least recently used
  logic [ROW_W-1:0]     tag_mem [SET_COUNT];
  logic [ROW_W-1:0]     row_q;
  logic [ROW_W-1:0]     row_shift;
  logic [ROW_W-1:0]     row_new;
  // Fill counts per set, with a flag per set that marks the count as written
  logic [FILL_W-1:0]    fill_mem [SET_COUNT];
  logic [SET_COUNT-1:0] fill_vld_q;
  logic [FILL_W-1:0]    fill_rd_q;
  logic                 fill_vld_rd_q;
  logic [FILL_W-1:0]    fill_new;
  logic [SET_IDX_W-1:0] set_q;
  logic [TAG_BITS-1:0]  tag_q;

  logic                 issue, fire;
  logic [FILL_W-1:0]    fill_cur;
  logic                 full;
  logic [WAY_COUNT-1:0] match;
  logic                 hit;
  logic [FILL_W-1:0]    pos;
  logic [FILL_W-1:0]    first_mv;
  logic [FILL_W-1:0]    last;
  logic                 shift_en;

  logic             out_valid_q, out_valid_d;
  logic             hit_out_q;
  logic [CNT_W-1:0] hit_cnt_q, hit_cnt_d;
  logic [CNT_W-1:0] miss_cnt_q, miss_cnt_d;

  assign issue   = (state_q == S_READ) && q_valid_i;
  assign fire    = (state_q == S_EVAL) && (!out_valid_q || out_ready_i);
  assign q_pop_o = issue;

  // Sequence read and evaluate steps
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_READ: if (issue) state_d = S_EVAL;
      S_EVAL: if (fire)  state_d = S_READ;
      default: state_d = S_READ;
    endcase
  end

  // Compare the filled ways against the tag and pick the first match
  always_comb begin
    fill_cur = fill_vld_rd_q ? fill_rd_q : '0;
    full     = (fill_cur == FILL_W'(WAY_COUNT));
    for (int k = 0; k < WAY_COUNT; k++) begin
      match[k] = (FILL_W'(k) < fill_cur) && (row_q[k*TAG_BITS +: TAG_BITS] == tag_q);
    end
    pos = '0;
    for (int k = WAY_COUNT - 1; k >= 0; k--) begin
      if (match[k]) pos = FILL_W'(k);
    end
    hit      = |match;
    fill_new = (!hit && !full) ? fill_cur + 1'b1 : fill_cur;
  end

  // Build the reordered row: shift ways above the removed one down, new tag last
  always_comb begin
    shift_en  = hit || full;
    first_mv  = hit ? pos : '0;
    if (hit) begin
      last = fill_cur - 1'b1;
    end else if (full) begin
      last = FILL_W'(WAY_COUNT - 1);
    end else begin
      last = fill_cur;
    end
    row_shift = row_q >> TAG_BITS;
    for (int k = 0; k < WAY_COUNT; k++) begin
      if (FILL_W'(k) == last) begin
        row_new[k*TAG_BITS +: TAG_BITS] = tag_q;
      end else if (shift_en && (FILL_W'(k) >= first_mv) && (FILL_W'(k) < last)) begin
        row_new[k*TAG_BITS +: TAG_BITS] = row_shift[k*TAG_BITS +: TAG_BITS];
      end else begin
        row_new[k*TAG_BITS +: TAG_BITS] = row_q[k*TAG_BITS +: TAG_BITS];
      end
    end
  end

  // Saturating totals and result handshake
  always_comb begin
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (fire) begin
      out_valid_d = 1'b1;
      if (hit) begin
        if (hit_cnt_q != CNT_MAX) hit_cnt_d = hit_cnt_q + 1'b1;
      end else begin
        if (miss_cnt_q != CNT_MAX) miss_cnt_d = miss_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_READ;
      out_valid_q <= 1'b0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      fill_vld_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      if (fire) begin
        fill_vld_q[set_q] <= 1'b1;
      end
    end
  end

  // Latch the word in flight and the hit flag
  always_ff @(posedge clk_i) begin
    if (issue) begin
      set_q         <= q_set_i;
      tag_q         <= q_tag_i;
      fill_vld_rd_q <= fill_vld_q[q_set_i];
    end
    if (fire) begin
      hit_out_q <= hit;
    end
  end

  // Row and fill memories: registered read in the read step, write back in the evaluate step
  always_ff @(posedge clk_i) begin
    if (fire) begin
      tag_mem[set_q]  <= row_new;
      fill_mem[set_q] <= fill_new;
    end
    if (issue) begin
      row_q     <= tag_mem[q_set_i];
      fill_rd_q <= fill_mem[q_set_i];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_out_q;
  assign hit_total_o  = hit_cnt_q;
  assign miss_total_o = miss_cnt_q;

endmodule

// ----- rtl/core/set_assoc_cache_lru_lookup.sv -----
// Top level of the set-associative cache tag lookup with true LRU replacement.
// Each input word is a byte address; the block returns one result word per
// address: hit or miss plus saturating running hit and miss totals. The set
// index is the address bits just above the line offset and the tag the bits
// above those; SET_COUNT must be a power of two. The lookup takes a new
// address only once it is through with the last one, set by the single-port
// read-modify-write of one set row (read step, then compare, reorder and
// write-back step); each result is registered. A two-word queue between the
// decode and the lookup lets addresses still be taken while a result waits,
// until the queue fills. Each set's fill count sits in a small memory beside a
// per-set written flag that clears at reset, so no clearing pass is needed.
module set_assoc_cache_lru_lookup #(
  parameter int unsigned SET_COUNT        = 64,
  parameter int unsigned WAY_COUNT        = 8,
  parameter int unsigned LINE_OFFSET_BITS = 6,
  parameter int unsigned TAG_BITS         = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [sclru_pkg::ADDR_W-1:0] address_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o,
  output logic [sclru_pkg::CNT_W-1:0]  hit_total_o,
  output logic [sclru_pkg::CNT_W-1:0]  miss_total_o
);
  import sclru_pkg::*;

  localparam int unsigned SET_IDX_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int unsigned ENTRY_W   = SET_IDX_W + TAG_BITS;

  logic                 push_valid, push_ready;
  logic [SET_IDX_W-1:0] push_set, pop_set;
  logic [TAG_BITS-1:0]  push_tag, pop_tag;
  logic                 pop_valid, pop;

  sclru_front #(
    .SET_COUNT       (SET_COUNT),
    .LINE_OFFSET_BITS(LINE_OFFSET_BITS),
    .TAG_BITS        (TAG_BITS),
    .SET_IDX_W       (SET_IDX_W)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .address_i   (address_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_set_o  (push_set),
    .push_tag_o  (push_tag)
  );

  sclru_queue #(
    .DATA_W(ENTRY_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i ({push_set, push_tag}),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_data_o  ({pop_set, pop_tag})
  );

  sclru_back #(
    .SET_COUNT(SET_COUNT),
    .WAY_COUNT(WAY_COUNT),
    .TAG_BITS (TAG_BITS),
    .SET_IDX_W(SET_IDX_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (pop_valid),
    .q_pop_o     (pop),
    .q_set_i     (pop_set),
    .q_tag_i     (pop_tag),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hit_o       (hit_o),
    .hit_total_o (hit_total_o),
    .miss_total_o(miss_total_o)
  );

endmodule

// ----- rtl/core/sclru_checker.sv -----
// Port-level checks for the LRU tag lookup, bound to the top level.
module sclru_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [sclru_pkg::ADDR_W-1:0] address_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         hit_o,
  input logic [sclru_pkg::CNT_W-1:0]  hit_total_o,
  input logic [sclru_pkg::CNT_W-1:0]  miss_total_o
);

  // A waiting address word holds until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=> (in_valid_i && $stable(address_i)))
    else $error("waiting address word changed");

  // A hit word always carries a nonzero hit total
  a_hit_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o) |-> (hit_total_o != '0))
    else $error("hit reported with zero hit total");

  // A miss word always carries a nonzero miss total
  a_miss_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (miss_total_o != '0))
    else $error("miss reported with zero miss total");

  // Totals never go down from one word to the next
  a_totals_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) ##1 out_valid_o |->
      (hit_total_o >= $past(hit_total_o)) && (miss_total_o >= $past(miss_total_o)))
    else $error("running totals decreased");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(hit_o) && $stable(hit_total_o) && $stable(miss_total_o)))
    else $error("stalled result word changed");

endmodule

bind set_assoc_cache_lru_lookup sclru_checker u_sclru_checker (.*);
